>>> rtl/pcc_pkg.sv
// shared types, codes and fixed-point helpers for the cylinder contact pipeline
// used by every module of the block; no dependencies
package pcc_pkg;

	localparam int POSE_WORDS = 18;
	localparam int IDX_TRANS  = 9;
	localparam int IDX_ANGV   = 12;
	localparam int IDX_LINV   = 15;
	localparam int ROT_FRAC   = 30;
	localparam int Q_FRAC     = 16;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	typedef logic signed [31:0] word_t;
	typedef logic signed [47:0] prod_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_CAP  = 2'd1,
		ST_AXIS = 2'd2
	} cstat_t;

	typedef struct packed {
		word_t [8:0] rot;
		word_t [2:0] trans;
		word_t [2:0] angv;
		word_t [2:0] linv;
	} pose_t;

	typedef struct packed {
		logic        vld;
		cstat_t      st;
		word_t [2:0] x;
		word_t [2:0] xdot;
		word_t [2:0] pv;
	} fe_t;

	typedef struct packed {
		logic        vld;
		cstat_t      st;
		word_t [2:0] x;
		word_t [2:0] xdot;
		word_t [2:0] pv;
		word_t       d;
		word_t       n2x;
		word_t       n2y;
	} dv_t;

	typedef struct packed {
		logic        vld;
		cstat_t      st;
		word_t       sdist;
		word_t [2:0] n;
		word_t       speed;
		word_t [2:0] tv;
		word_t [2:0] sp;
	} res_t;

	function automatic logic signed [63:0] sx(input logic signed [31:0] a);
		logic signed [63:0] r;
		r = a;
		return r;
	endfunction

	function automatic logic signed [63:0] sx48(input logic signed [47:0] a);
		logic signed [63:0] r;
		r = a;
		return r;
	endfunction

	function automatic word_t sat64(input logic signed [63:0] v);
		word_t r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// product rounded half up to the rotation fraction
	function automatic prod_t mr(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] ae;
		logic signed [63:0] be;
		logic signed [63:0] p;
		ae = a;
		be = b;
		p = ae * be + (64'sd1 <<< (ROT_FRAC - 1));
		p = p >>> ROT_FRAC;
		return p[47:0];
	endfunction

	// product rounded half up to the q16.16 fraction
	function automatic prod_t mq(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] ae;
		logic signed [63:0] be;
		logic signed [63:0] p;
		ae = a;
		be = b;
		p = ae * be + (64'sd1 <<< (Q_FRAC - 1));
		p = p >>> Q_FRAC;
		return p[47:0];
	endfunction

endpackage

>>> rtl/point_cylinder_contact.sv
// Point against cylinder side surface contact query, top level.
// Item channel (item_valid / item_stall): op 0 stores one of 18 pose words,
// op 1 queries a world point and its velocity. Result channel
// (result_valid / result_stall) gives one result per query, none per write.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 radius,
// index 1 length; write it only while no query is in flight.
// Pipeline: 5 transform stages, 32 square root stages, 32 divider stages and
// 10 output stages. Throughput: one query per cycle unless result_stall
// freezes the pipeline. A pose write waits at the item port until
// queries still in flight have left the stages that read the pose.
// result_stall with a result waiting freezes the whole pipeline and raises
// item_stall; nothing is lost or repeated.
// Reset clears valid bits and the two config registers; the pose words are
// undefined until written and all 18 must be written before the first query.
// depends on pcc_pkg, pcc_front, pcc_sqrt, pcc_div, pcc_back
module point_cylinder_contact import pcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        op,
	input  logic [4:0]  word_index,
	input  word_t       word_value,
	input  word_t       point_x,
	input  word_t       point_y,
	input  word_t       point_z,
	input  word_t       point_vel_x,
	input  word_t       point_vel_y,
	input  word_t       point_vel_z,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  contact_status,
	output word_t       surface_distance,
	output word_t       normal_x,
	output word_t       normal_y,
	output word_t       normal_z,
	output word_t       approach_speed,
	output word_t       tangent_vel_x,
	output word_t       tangent_vel_y,
	output word_t       tangent_vel_z,
	output word_t       surface_point_x,
	output word_t       surface_point_y,
	output word_t       surface_point_z
);

	word_t pose_q [POSE_WORDS];
	logic [30:0] radius_q, length_q;
	pose_t pose;

	logic en, busy, qry, wr;
	logic fe_busy, sq_busy, dv_busy, be_busy;
	fe_t fe_side, sq_side;
	logic [63:0] sq;
	logic [31:0] root;
	dv_t dv_side;
	res_t res;

	assign en = !(res.vld && result_stall);
	assign busy = fe_busy | sq_busy | dv_busy | be_busy;
	assign item_stall = !en || (op == OP_WRITE && busy);
	assign qry = item_valid && !item_stall && op == OP_QUERY;
	assign wr = item_valid && !item_stall && op == OP_WRITE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (wr && word_index < 5'(POSE_WORDS))
			pose_q[word_index] <= word_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			length_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[30:0];
				REG_LENGTH: length_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++)
			pose.rot[k] = pose_q[k];
		for (int k = 0; k < 3; k++) begin
			pose.trans[k] = pose_q[IDX_TRANS + k];
			pose.angv[k] = pose_q[IDX_ANGV + k];
			pose.linv[k] = pose_q[IDX_LINV + k];
		end
	end

	pcc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.qry    (qry),
		.pose   (pose),
		.length (length_q),
		.px     (point_x),
		.py     (point_y),
		.pz     (point_z),
		.vx     (point_vel_x),
		.vy     (point_vel_y),
		.vz     (point_vel_z),
		.side   (fe_side),
		.sq     (sq),
		.busy   (fe_busy)
	);

	pcc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (fe_side),
		.sq_in    (sq),
		.side_out (sq_side),
		.root     (root),
		.busy     (sq_busy)
	);

	pcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.radius   (radius_q),
		.side_in  (sq_side),
		.root     (root),
		.side_out (dv_side),
		.busy     (dv_busy)
	);

	pcc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.pose    (pose),
		.side_in (dv_side),
		.res     (res),
		.busy    (be_busy)
	);

	assign result_valid = res.vld;
	assign contact_status = res.st;
	assign surface_distance = res.sdist;
	assign normal_x = res.n[0];
	assign normal_y = res.n[1];
	assign normal_z = res.n[2];
	assign approach_speed = res.speed;
	assign tangent_vel_x = res.tv[0];
	assign tangent_vel_y = res.tv[1];
	assign tangent_vel_z = res.tv[2];
	assign surface_point_x = res.sp[0];
	assign surface_point_y = res.sp[1];
	assign surface_point_z = res.sp[2];

endmodule

>>> rtl/pcc_front.sv
// front stages: world to body transform of point and velocity, end cap test,
// squared radial length; depends on pcc_pkg
module pcc_front import pcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        qry,
	input  pose_t       pose,
	input  logic [30:0] length,
	input  word_t       px,
	input  word_t       py,
	input  word_t       pz,
	input  word_t       vx,
	input  word_t       vy,
	input  word_t       vz,
	output fe_t         side,
	output logic [63:0] sq,
	output logic        busy
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	word_t diff_s1 [3];
	word_t pv_s1 [3];
	prod_t px_s2 [3][3];
	prod_t pr_s2 [3][3];
	word_t pv_s2 [3];
	word_t x_s3 [3];
	word_t rv_s3 [3];
	word_t pv_s3 [3];
	prod_t ca_s4 [3];
	prod_t cb_s4 [3];
	logic [62:0] sqa_s4, sqb_s4;
	logic cap_s4;
	word_t x_s4 [3];
	word_t rv_s4 [3];
	word_t pv_s4 [3];
	fe_t side_s5;
	logic [63:0] sq_s5;

	word_t pin [3];
	word_t vin [3];
	logic signed [63:0] x0e, x1e, sqa_c, sqb_c, z2, lenw;

	assign pin[0] = px;
	assign pin[1] = py;
	assign pin[2] = pz;
	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	always_comb begin
		x0e = sx(x_s3[0]);
		x1e = sx(x_s3[1]);
		sqa_c = x0e * x0e;
		sqb_c = x1e * x1e;
		z2 = sx(x_s3[2]) <<< 1;
		lenw = {33'b0, length};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= qry;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= sat64(sx(pin[i]) - sx(pose.trans[i]));
				pv_s1[i] <= vin[i];
			end
			// rotation transposed applied to offset and velocity
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					px_s2[i][j] <= mr(pose.rot[j*3+i], diff_s1[j]);
					pr_s2[i][j] <= mr(pose.rot[j*3+i], pv_s1[j]);
				end
				pv_s2[i] <= pv_s1[i];
			end
			for (int i = 0; i < 3; i++) begin
				x_s3[i] <= sat64(sx48(px_s2[i][0]) + sx48(px_s2[i][1]) + sx48(px_s2[i][2]));
				rv_s3[i] <= sat64(sx48(pr_s2[i][0]) + sx48(pr_s2[i][1]) + sx48(pr_s2[i][2]));
				pv_s3[i] <= pv_s2[i];
			end
			ca_s4[0] <= mq(x_s3[1], pose.angv[2]);
			cb_s4[0] <= mq(x_s3[2], pose.angv[1]);
			ca_s4[1] <= mq(x_s3[2], pose.angv[0]);
			cb_s4[1] <= mq(x_s3[0], pose.angv[2]);
			ca_s4[2] <= mq(x_s3[0], pose.angv[1]);
			cb_s4[2] <= mq(x_s3[1], pose.angv[0]);
			sqa_s4 <= sqa_c[62:0];
			sqb_s4 <= sqb_c[62:0];
			cap_s4 <= (z2 < -lenw) || (z2 > lenw);
			for (int i = 0; i < 3; i++) begin
				x_s4[i] <= x_s3[i];
				rv_s4[i] <= rv_s3[i];
				pv_s4[i] <= pv_s3[i];
			end
			side_s5.vld <= v_s4;
			side_s5.st <= cap_s4 ? ST_CAP : ST_OK;
			for (int i = 0; i < 3; i++) begin
				side_s5.x[i] <= x_s4[i];
				side_s5.pv[i] <= pv_s4[i];
				side_s5.xdot[i] <= sat64(sx(sat64(sx48(ca_s4[i]) - sx48(cb_s4[i])))
					+ sx(rv_s4[i]) - sx(pose.linv[i]));
			end
			sq_s5 <= {1'b0, sqa_s4} + {1'b0, sqb_s4};
		end
	end

	always_comb begin
		side = side_s5;
		side.vld = v_s5;
	end
	assign sq = sq_s5;
	assign busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

endmodule

>>> rtl/pcc_sqrt.sv
// pipelined floor square root, one result bit per stage, with side data
// carried alongside; depends on pcc_pkg
module pcc_sqrt import pcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  fe_t         side_in,
	input  logic [63:0] sq_in,
	output fe_t         side_out,
	output logic [31:0] root,
	output logic        busy
);

	fe_t        side_s [SQRT_STEPS];
	logic [63:0] rem_s [SQRT_STEPS];
	logic [63:0] res_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
		fe_t         sd;
		logic [63:0] rm;
		logic [63:0] rs;
		logic [63:0] trial;
		logic        ge;
		if (k == 0) begin : g_first
			assign sd = side_in;
			assign rm = sq_in;
			assign rs = '0;
		end else begin : g_next
			assign sd = side_s[k-1];
			assign rm = rem_s[k-1];
			assign rs = res_s[k-1];
		end
		assign trial = rs + BIT;
		assign ge = rm >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (en) begin
				side_s[k] <= sd;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rm - trial : rm;
				res_s[k] <= ge ? (rs >> 1) + BIT : rs >> 1;
			end
		end
	end

	always_comb begin
		busy = 1'b0;
		for (int k = 0; k < SQRT_STEPS; k++)
			busy = busy | side_s[k].vld;
	end

	assign side_out = side_s[SQRT_STEPS-1];
	assign root = res_s[SQRT_STEPS-1][31:0];

endmodule

>>> rtl/pcc_div.sv
// radial distance and body normal: two restoring dividers, one quotient bit
// per stage, computing x/r and y/r in q2.30; depends on pcc_pkg
module pcc_div import pcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [30:0] radius,
	input  fe_t         side_in,
	input  logic [31:0] root,
	output dv_t         side_out,
	output logic        busy
);

	dv_t         side_s [DIV_STEPS+1];
	logic [31:0] r_s    [DIV_STEPS+1];
	logic [31:0] remx_s [DIV_STEPS+1];
	logic [30:0] qx_s   [DIV_STEPS+1];
	logic [31:0] remy_s [DIV_STEPS+1];
	logic [30:0] qy_s   [DIV_STEPS+1];
	logic        sgx_s  [DIV_STEPS+1];
	logic        sgy_s  [DIV_STEPS+1];

	logic [31:0] magx, magy;
	logic [62:0] nx, ny;
	dv_t prep;

	always_comb begin
		magx = side_in.x[0][31] ? 32'(-side_in.x[0]) : side_in.x[0];
		magy = side_in.x[1][31] ? 32'(-side_in.x[1]) : side_in.x[1];
		// rounding term r/2 folded into the dividend
		nx = ({31'b0, magx} << ROT_FRAC) + {32'b0, root[31:1]};
		ny = ({31'b0, magy} << ROT_FRAC) + {32'b0, root[31:1]};
		prep.vld = side_in.vld;
		prep.st = (side_in.st == ST_OK && root == 32'd0) ? ST_AXIS : side_in.st;
		prep.x = side_in.x;
		prep.xdot = side_in.xdot;
		prep.pv = side_in.pv;
		prep.d = sat64({32'b0, root} - {33'b0, radius});
		prep.n2x = '0;
		prep.n2y = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else if (en) begin
			side_s[0] <= prep;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= root;
			remx_s[0] <= nx[62:31];
			qx_s[0] <= nx[30:0];
			remy_s[0] <= ny[62:31];
			qy_s[0] <= ny[30:0];
			sgx_s[0] <= side_in.x[0][31];
			sgy_s[0] <= side_in.x[1][31];
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [32:0] tx, ty;
		logic        gex, gey;
		assign tx = {remx_s[k-1], qx_s[k-1][30]};
		assign ty = {remy_s[k-1], qy_s[k-1][30]};
		assign gex = tx >= {1'b0, r_s[k-1]};
		assign gey = ty >= {1'b0, r_s[k-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (en) begin
				side_s[k] <= side_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= r_s[k-1];
				remx_s[k] <= gex ? 32'(tx - {1'b0, r_s[k-1]}) : tx[31:0];
				remy_s[k] <= gey ? 32'(ty - {1'b0, r_s[k-1]}) : ty[31:0];
				qx_s[k] <= {qx_s[k-1][29:0], gex};
				qy_s[k] <= {qy_s[k-1][29:0], gey};
				sgx_s[k] <= sgx_s[k-1];
				sgy_s[k] <= sgy_s[k-1];
			end
		end
	end

	always_comb begin
		side_out = side_s[DIV_STEPS];
		side_out.n2x = sgx_s[DIV_STEPS] ? -word_t'({1'b0, qx_s[DIV_STEPS]})
			: word_t'({1'b0, qx_s[DIV_STEPS]});
		side_out.n2y = sgy_s[DIV_STEPS] ? -word_t'({1'b0, qy_s[DIV_STEPS]})
			: word_t'({1'b0, qy_s[DIV_STEPS]});
		busy = 1'b0;
		for (int k = 0; k <= DIV_STEPS; k++)
			busy = busy | side_s[k].vld;
	end

endmodule

>>> rtl/pcc_back.sv
// back stages: world normal, normal speed, surface point, surface velocity
// and tangential velocity; last stage is the result register; depends on pcc_pkg
module pcc_back import pcc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  pose_t pose,
	input  dv_t   side_in,
	output res_t  res,
	output logic  busy
);

	typedef struct packed {
		cstat_t      st;
		word_t       d;
		word_t       ddot;
		word_t [2:0] n;
		word_t [2:0] xi;
		word_t [2:0] pv;
	} keep_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	prod_t nr_s1 [3][2];
	prod_t dd_s1 [2];
	prod_t xd_s1 [2];
	cstat_t st_s1;
	word_t d_s1;
	word_t x_s1 [3];
	word_t pv_s1 [3];

	keep_t k_s2, k_s3, k_s4, k_s5, k_s6, k_s7, k_s8, k_s9;
	prod_t ca_s3 [3];
	prod_t cb_s3 [3];
	word_t u_s4 [3];
	prod_t ur_s5 [3][3];
	word_t vw_s6 [3];
	word_t vw_s7 [3];
	word_t vw_s8 [3];
	word_t vw_s9 [3];
	prod_t np_s7 [3];
	word_t nv_s8;
	prod_t tp_s9 [3];
	res_t  res_s10;

	word_t sv [3];
	word_t tv [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			sv[i] = sat64(sx48(ur_s5[i][0]) + sx48(ur_s5[i][1]) + sx48(ur_s5[i][2]));
		for (int i = 0; i < 3; i++)
			tv[i] = sat64(sx(vw_s9[i]) - sx48(tp_s9[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1 <= side_in.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// body normal has no z part, so only two columns of the rotation count
			for (int i = 0; i < 3; i++) begin
				nr_s1[i][0] <= mr(pose.rot[i*3], side_in.n2x);
				nr_s1[i][1] <= mr(pose.rot[i*3+1], side_in.n2y);
				x_s1[i] <= side_in.x[i];
				pv_s1[i] <= side_in.pv[i];
			end
			dd_s1[0] <= mr(side_in.n2x, side_in.xdot[0]);
			dd_s1[1] <= mr(side_in.n2y, side_in.xdot[1]);
			xd_s1[0] <= mr(side_in.d, side_in.n2x);
			xd_s1[1] <= mr(side_in.d, side_in.n2y);
			st_s1 <= side_in.st;
			d_s1 <= side_in.d;

			k_s2.st <= st_s1;
			k_s2.d <= d_s1;
			k_s2.ddot <= sat64(sx48(dd_s1[0]) + sx48(dd_s1[1]));
			for (int i = 0; i < 3; i++) begin
				k_s2.n[i] <= sat64(sx48(nr_s1[i][0]) + sx48(nr_s1[i][1]));
				k_s2.pv[i] <= pv_s1[i];
			end
			k_s2.xi[0] <= sat64(sx(x_s1[0]) - sx48(xd_s1[0]));
			k_s2.xi[1] <= sat64(sx(x_s1[1]) - sx48(xd_s1[1]));
			k_s2.xi[2] <= x_s1[2];

			ca_s3[0] <= mq(pose.angv[1], k_s2.xi[2]);
			cb_s3[0] <= mq(pose.angv[2], k_s2.xi[1]);
			ca_s3[1] <= mq(pose.angv[2], k_s2.xi[0]);
			cb_s3[1] <= mq(pose.angv[0], k_s2.xi[2]);
			ca_s3[2] <= mq(pose.angv[0], k_s2.xi[1]);
			cb_s3[2] <= mq(pose.angv[1], k_s2.xi[0]);
			k_s3 <= k_s2;

			for (int i = 0; i < 3; i++)
				u_s4[i] <= sat64(sx(sat64(sx48(ca_s3[i]) - sx48(cb_s3[i])))
					+ sx(pose.linv[i]));
			k_s4 <= k_s3;

			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					ur_s5[i][j] <= mr(pose.rot[i*3+j], u_s4[j]);
			k_s5 <= k_s4;

			for (int i = 0; i < 3; i++)
				vw_s6[i] <= sat64(sx(k_s5.pv[i]) - sx(sv[i]));
			k_s6 <= k_s5;

			for (int i = 0; i < 3; i++) begin
				np_s7[i] <= mr(k_s6.n[i], vw_s6[i]);
				vw_s7[i] <= vw_s6[i];
			end
			k_s7 <= k_s6;

			nv_s8 <= sat64(sx48(np_s7[0]) + sx48(np_s7[1]) + sx48(np_s7[2]));
			vw_s8 <= vw_s7;
			k_s8 <= k_s7;

			for (int i = 0; i < 3; i++)
				tp_s9[i] <= mr(k_s8.n[i], nv_s8);
			vw_s9 <= vw_s8;
			k_s9 <= k_s8;

			// end cap and on-axis results carry only the status
			res_s10.vld <= v_s9;
			res_s10.st <= k_s9.st;
			if (k_s9.st == ST_OK) begin
				res_s10.sdist <= k_s9.d;
				res_s10.speed <= k_s9.ddot;
				for (int i = 0; i < 3; i++) begin
					res_s10.n[i] <= k_s9.n[i];
					res_s10.tv[i] <= tv[i];
					res_s10.sp[i] <= k_s9.xi[i];
				end
			end else begin
				res_s10.sdist <= '0;
				res_s10.speed <= '0;
				res_s10.n <= '0;
				res_s10.tv <= '0;
				res_s10.sp <= '0;
			end
		end
	end

	always_comb begin
		res = res_s10;
		res.vld = v_s10;
	end
	assign busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7 | v_s8 | v_s9;

endmodule
